// ===== rtl/mmn_pkg.sv =====
`timescale 1ns / 1ps

package mmn_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int VALUE_W   = SAMPLE_W + 1;   // decoded sample, signed
  localparam int RANGE_W   = VALUE_W + 1;    // difference of two samples
  localparam int QUOT_W    = 8;
  localparam int ALU_W     = RANGE_W + QUOT_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic REG_SIGNED = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  // sample width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  // item actions
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef struct packed {
    logic        action;
    logic        first;
    logic [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       range_zero;
  } out_item_t;

  typedef struct packed {
    logic       signed_samples;
    logic [1:0] sample_width_code;
  } cfg_t;

  // low-aligned raw bits to a signed value, per configured format
  function automatic logic signed [VALUE_W-1:0] decode_sample(
    input logic [SAMPLE_W-1:0] raw,
    input cfg_t                cfg
  );
    logic ext;
    logic signed [VALUE_W-1:0] v;
    ext = 1'b0;
    v   = '0;
    case (cfg.sample_width_code)
      WIDTH_8: begin
        ext = cfg.signed_samples & raw[7];
        v   = {{(VALUE_W-8){ext}}, raw[7:0]};
      end
      WIDTH_16: begin
        ext = cfg.signed_samples & raw[15];
        v   = {{(VALUE_W-16){ext}}, raw[15:0]};
      end
      default: begin
        ext = cfg.signed_samples & raw[SAMPLE_W-1];
        v   = {ext, raw};
      end
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mmn_cfg.sv =====
`timescale 1ns / 1ps

module mmn_cfg
  import mmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SIGNED: cfg_r.signed_samples    <= pwdata[0];
        REG_WIDTH:  cfg_r.sample_width_code <= pwdata[1:0];
        default:    cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIGNED: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.signed_samples};
      REG_WIDTH:  prdata = {{(CFG_DATA_W-2){1'b0}}, cfg_r.sample_width_code};
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mmn_alu.sv =====
`timescale 1ns / 1ps

// Shared subtractor: the min/max compares, the offset-to-range compare, the
// range, the offset, the x255 scale and each restoring division step go here.
module mmn_alu
  import mmn_pkg::*;
(
  input  logic signed [ALU_W-1:0] op_a,
  input  logic signed [ALU_W-1:0] op_b,
  output logic signed [ALU_W-1:0] diff,
  output logic                    neg,
  output logic                    pos
);

  assign diff = op_a - op_b;
  assign neg  = diff[ALU_W-1];
  assign pos  = ~diff[ALU_W-1] & (|diff);

endmodule

// ===== rtl/mmn_core.sv =====
`timescale 1ns / 1ps

module mmn_core
  import mmn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic                      in_first,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAX   = 4'd1;
  localparam logic [3:0] S_MIN   = 4'd2;
  localparam logic [3:0] S_RANGE = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic signed [VALUE_W-1:0] x_r, x_nxt;
  logic signed [VALUE_W-1:0] min_r, min_nxt;
  logic signed [VALUE_W-1:0] max_r, max_nxt;
  logic                      have_r, have_nxt;
  logic                      first_r, first_nxt;
  logic signed [RANGE_W-1:0] range_r, range_nxt;
  logic signed [RANGE_W-1:0] diff_r, diff_nxt;
  logic [VALUE_W-1:0]        rem_r, rem_nxt;
  logic [QUOT_W-1:0]         low_r, low_nxt;
  logic [QUOT_W-1:0]         quot_r, quot_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic [7:0]                pix_r, pix_nxt;
  logic                      rz_r, rz_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_r, out_nxt;

  logic signed [ALU_W-1:0] op_a, op_b, alu_diff;
  logic                    alu_neg, alu_pos;
  logic [RANGE_W-1:0]      trial;

  mmn_alu u_alu (
    .op_a (op_a),
    .op_b (op_b),
    .diff (alu_diff),
    .neg  (alu_neg),
    .pos  (alu_pos)
  );

  // next partial remainder: shift in one numerator bit
  assign trial = {rem_r, low_r[QUOT_W-1]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_MAX: begin
        op_a = {{(ALU_W-VALUE_W){x_r[VALUE_W-1]}}, x_r};
        op_b = {{(ALU_W-VALUE_W){max_r[VALUE_W-1]}}, max_r};
      end
      S_MIN, S_DIFF: begin
        op_a = {{(ALU_W-VALUE_W){x_r[VALUE_W-1]}}, x_r};
        op_b = {{(ALU_W-VALUE_W){min_r[VALUE_W-1]}}, min_r};
      end
      S_RANGE: begin
        op_a = {{(ALU_W-VALUE_W){max_r[VALUE_W-1]}}, max_r};
        op_b = {{(ALU_W-VALUE_W){min_r[VALUE_W-1]}}, min_r};
      end
      S_CMP: begin
        op_a = {{(ALU_W-RANGE_W){diff_r[RANGE_W-1]}}, diff_r};
        op_b = {{(ALU_W-RANGE_W){range_r[RANGE_W-1]}}, range_r};
      end
      S_SCALE: begin
        // diff * 255 as (diff << 8) - diff
        op_a = {diff_r, {QUOT_W{1'b0}}};
        op_b = {{(ALU_W-RANGE_W){diff_r[RANGE_W-1]}}, diff_r};
      end
      S_DIV: begin
        op_a = {{(ALU_W-RANGE_W){1'b0}}, trial};
        op_b = {{(ALU_W-RANGE_W){range_r[RANGE_W-1]}}, range_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    have_nxt      = have_r;
    first_nxt     = first_r;
    range_nxt     = range_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    pix_nxt       = pix_r;
    rz_nxt        = rz_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_value;
          first_nxt = in_first;
          state_nxt = (in_action == ACT_CONVERT) ? S_RANGE : S_MAX;
        end
      end
      S_MAX: begin
        if (first_r || !have_r) begin
          min_nxt   = x_r;
          max_nxt   = x_r;
          have_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (alu_pos) max_nxt = x_r;
          state_nxt = S_MIN;
        end
      end
      S_MIN: begin
        if (alu_neg) min_nxt = x_r;
        state_nxt = S_IDLE;
      end
      S_RANGE: begin
        range_nxt = alu_diff[RANGE_W-1:0];
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        diff_nxt = alu_diff[RANGE_W-1:0];
        pix_nxt  = '0;
        rz_nxt   = 1'b0;
        if (range_r[RANGE_W-1] || range_r == '0) begin
          rz_nxt    = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (diff_r[RANGE_W-1] || diff_r == '0) begin
          state_nxt = S_OUT;
        end else if (!alu_neg) begin
          pix_nxt   = 8'hFF;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        // numerator below 256 * range, so its top bits start below the divisor
        rem_nxt   = alu_diff[ALU_W-2:QUOT_W];
        low_nxt   = alu_diff[QUOT_W-1:0];
        quot_nxt  = '0;
        cnt_nxt   = '1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        low_nxt = {low_r[QUOT_W-2:0], 1'b0};
        if (alu_neg) begin
          rem_nxt  = trial[VALUE_W-1:0];
          quot_nxt = {quot_r[QUOT_W-2:0], 1'b0};
        end else begin
          rem_nxt  = alu_diff[VALUE_W-1:0];
          quot_nxt = {quot_r[QUOT_W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          pix_nxt   = quot_nxt;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait here only while the previous result is still held
        if (!out_valid_r || out_ready) begin
          out_nxt.pixel      = pix_r;
          out_nxt.range_zero = rz_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= '0;
      max_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    first_r <= first_nxt;
    range_r <= range_nxt;
    diff_r  <= diff_nxt;
    rem_r   <= rem_nxt;
    low_r   <= low_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
    pix_r   <= pix_nxt;
    rz_r    <= rz_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/min_max_normalize_to_8bit_unit.sv =====
`timescale 1ns / 1ps

// Min/max normalisation of integer samples to 8-bit grey levels.
// Input channel (in_valid/in_ready/in_data): measure items (action 0) fold
// the sample into the running minimum and maximum, first restarting the
// pass; convert items (action 1) each give one result item on the output
// channel (out_valid/out_ready/out_data): pixel = floor((x-min)*255/range),
// saturated, or 0 with range_zero set when max equals min.
// The APB port (cfg_*) sets signedness (0x0) and sample width (0x4); write
// it only while the block is idle. pready is always high.
// Sequencing: one item at a time, on one shared subtractor. A measure item
// visits only S_MAX with first set or nothing tracked, else also S_MIN. A
// convert item goes through range, offset, range compare, x255 scale, 8
// restoring steps and output before out_valid rises, skipping to output
// after the compare when the offset saturates and after the offset when the
// range is zero; the next item is accepted in the cycle out_valid rises. The
// result sits in an output register while it waits. If a second result is
// ready before the first is taken, the block holds it and stops accepting
// until out_ready. Reset (rst_n low, synchronous) clears the configuration
// registers, min, max and the measured flag, goes idle, drops out_valid.
module min_max_normalize_to_8bit_unit
  import mmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                      cfg;
  logic signed [VALUE_W-1:0] in_value;

  mmn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign in_value   = decode_sample(in_data.sample, cfg);
  assign cfg_pready = 1'b1;

  mmn_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .in_first  (in_data.first),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
